// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hcbd_pkg.sv =====
// Package for the chunked body decoder: widths, characters, phase and error codes,
// result type and the hex digit decoder. No dependencies.
package hcbd_pkg;

  localparam int unsigned SizeWidth = 64;  // chunk size accumulator, 16..64
  localparam int unsigned LenWidth  = 64;  // decoded length counter
  localparam int unsigned ByteWidth = 8;

  localparam logic [ByteWidth-1:0] ChCr = 8'h0D;
  localparam logic [ByteWidth-1:0] ChLf = 8'h0A;

  typedef enum logic [2:0] {
    PhSize,
    PhSizeLf,
    PhData,
    PhDataLf,
    PhTrailer,
    PhTrailerLf
  } phase_e;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrSizeLine = 2'd1,
    ErrFraming  = 2'd2
  } err_e;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 data_valid;
    logic                 done_res;
    logic [1:0]           error_code;
    logic [LenWidth-1:0]  decoded_length;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

  // {digit ok, digit value}
  function automatic logic [4:0] hex_value(input logic [ByteWidth-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/hcbd_in_if.sv =====
// Input channel of the chunked body decoder: one received byte per transaction.
// Depends on hcbd_pkg.
interface hcbd_in_if;
  logic                           valid;
  logic                           ready;
  logic [hcbd_pkg::ByteWidth-1:0] byte_in;
  logic                           in_body;

  modport source (output valid, output byte_in, output in_body, input ready);
  modport sink   (input valid, input byte_in, input in_body, output ready);
endinterface

// ===== rtl/hcbd_out_if.sv =====
// Output channel of the chunked body decoder: one result per transaction.
// Depends on hcbd_pkg.
interface hcbd_out_if;
  logic                           valid;
  logic                           ready;
  logic [hcbd_pkg::ByteWidth-1:0] data_byte;
  logic                           data_valid;
  logic                           done_res;
  logic [1:0]                     error_code;
  logic [hcbd_pkg::LenWidth-1:0]  decoded_length;

  modport source (output valid, output data_byte, output data_valid, output done_res,
                  output error_code, output decoded_length, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input done_res,
                  input error_code, input decoded_length, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if, hcbd_parser and hcbd_out_buf.
//
//   channel | dir | payload                                              | transaction
//   --------+-----+------------------------------------------------------+------------------
//   in_i    | in  | byte_in[7:0], in_body                                | valid && ready
//   out_o   | out | data_byte[7:0], data_valid, done_res, error_code[1:0],| valid && ready
//           |     | decoded_length[63:0]                                 |
//
// One byte per cycle while the buffer has room: each input transaction updates the
// parser state in the cycle it is taken, and its result is registered in the buffer for out_o.
// The parser loop is combinational; its 64-bit decrement and increment set the path.
// A two-entry result buffer keeps input flowing while out_o stalls; in_i.ready
// drops only when both entries hold untaken results.
// rst_ni clears the parser and the buffer asynchronously; no clearing pass.
module http_chunked_body_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     in_i,
  hcbd_out_if.source  out_o
);
  import hcbd_pkg::*;

  logic    buf_ready;
  logic    accept;
  result_t res;
  push_t   wr;

  // Take a byte whenever the result buffer has a free entry.
  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  // Advance the framing state for the accepted byte; a header byte resets it.
  hcbd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (in_i.byte_in),
    .in_body_i (in_i.in_body),
    .res_o     (res)
  );

  // Every accepted byte yields exactly one result.
  assign wr.push = accept;
  assign wr.res  = res;

  // Hold results until the downstream side takes them.
  hcbd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/hcbd_parser.sv =====
// Chunked framing parser: state registers and the per-byte next-state logic.
// Depends on hcbd_pkg.
module hcbd_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [hcbd_pkg::ByteWidth-1:0] byte_i,
  input  logic                           in_body_i,
  output hcbd_pkg::result_t              res_o
);
  import hcbd_pkg::*;

  phase_e               phase_q, phase_d;
  logic [SizeWidth-1:0] acc_q, acc_d;
  logic [SizeWidth-1:0] rem_q, rem_d;
  logic [LenWidth-1:0]  cnt_q, cnt_d;
  err_e                 err_q, err_d;
  logic                 fin_q, fin_d;
  logic [4:0]           hex;
  logic                 pay;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    fin_d   = fin_q;
    pay     = 1'b0;
    hex     = hex_value(byte_i);
    if (!in_body_i) begin
      phase_d = PhSize;
      acc_d   = '0;
      rem_d   = '0;
      cnt_d   = '0;
      err_d   = ErrNone;
      fin_d   = 1'b0;
    end else if (err_q == ErrNone && !fin_q) begin
      case (phase_q)
        PhSize: begin
          if (byte_i == ChCr) begin
            phase_d = PhSizeLf;
          end else if (!hex[4] || acc_q[SizeWidth-1 -: 4] != 4'd0) begin
            err_d = ErrSizeLine;
          end else begin
            acc_d = {acc_q[SizeWidth-5:0], hex[3:0]};
            rem_d = SizeWidth'(1);
          end
        end
        PhSizeLf: begin
          if (byte_i != ChLf || rem_q == '0) begin
            err_d = ErrSizeLine;
          end else if (acc_q == '0) begin
            rem_d   = '0;
            phase_d = PhTrailer;
          end else begin
            rem_d   = acc_q;
            acc_d   = '0;
            phase_d = PhData;
          end
        end
        PhData: begin
          if (rem_q != '0) begin
            rem_d = rem_q - SizeWidth'(1);
            cnt_d = cnt_q + LenWidth'(1);
            pay   = 1'b1;
          end else if (byte_i == ChCr) begin
            phase_d = PhDataLf;
          end else begin
            err_d = ErrFraming;
          end
        end
        PhDataLf: begin
          if (byte_i != ChLf) begin
            err_d = ErrFraming;
          end else begin
            acc_d   = '0;
            rem_d   = '0;
            phase_d = PhSize;
          end
        end
        PhTrailer: begin
          if (byte_i == ChCr) begin
            phase_d = PhTrailerLf;
          end else begin
            rem_d = SizeWidth'(1);
          end
        end
        PhTrailerLf: begin
          if (byte_i == ChLf) begin
            if (rem_q == '0) begin
              fin_d = 1'b1;
            end
            rem_d   = '0;
            phase_d = PhTrailer;
          end else begin
            rem_d = SizeWidth'(1);
            if (byte_i != ChCr) begin
              phase_d = PhTrailer;
            end
          end
        end
        default: begin
          phase_d = PhSize;
        end
      endcase
    end

    res_o.data_byte      = pay ? byte_i : '0;
    res_o.data_valid     = pay;
    res_o.done_res       = fin_d;
    res_o.error_code     = err_d;
    res_o.decoded_length = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSize;
      acc_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      err_q   <= ErrNone;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ===== rtl/hcbd_out_buf.sv =====
// Two-entry result buffer that parts the parser from the output channel.
// Depends on hcbd_pkg and hcbd_out_if.
module hcbd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcbd_pkg::push_t     wr_i,
  output logic                ready_o,
  hcbd_out_if.source          out_o
);
  import hcbd_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  result_t    head;

  assign ready_o = (cnt_q != 2'd2);
  assign pop     = (cnt_q != 2'd0) && out_o.ready;
  assign head    = mem_q[rd_ptr_q];

  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.data_byte      = head.data_byte;
  assign out_o.data_valid     = head.data_valid;
  assign out_o.done_res       = head.done_res;
  assign out_o.error_code     = head.error_code;
  assign out_o.decoded_length = head.decoded_length;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i.push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr_i.push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.res;
    end
  end

endmodule

// ===== rtl/hcbd_checker.sv =====
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hcbd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [hcbd_pkg::ByteWidth-1:0] data_byte_i,
  input logic                           data_valid_i,
  input logic                           done_res_i,
  input logic [1:0]                     error_code_i
);
  import hcbd_pkg::*;

  `ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `ASSERT_IMP(a_pay_clean, out_valid_i && data_valid_i, error_code_i == ErrNone && !done_res_i, "late payload")
  `ASSERT_IMP(a_err_code, out_valid_i, error_code_i != 2'd3, "undefined error code")
  `ASSERT_IMP(a_byte_zero, out_valid_i && !data_valid_i, data_byte_i == '0, "stray data byte")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .data_byte_i  (out_o.data_byte),
  .data_valid_i (out_o.data_valid),
  .done_res_i   (out_o.done_res),
  .error_code_i (out_o.error_code)
);

// ===== tb/sv/tb_http_chunked_body_decoder.sv =====
// Self-checking testbench for the chunked body decoder: streams framed and broken bodies
// byte by byte and checks every result against a local model of the parser.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and the RTL top level.
module tb_http_chunked_body_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  // One input transaction; hold_back makes the sender wait until all results are in.
  typedef struct packed {
    logic [ByteWidth-1:0] c;
    logic                 body;
    logic                 hold_back;
  } rx_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1ns clk_i = ~clk_i;

  // Bytes still to send and results still owed by the block, oldest first.
  rx_byte_t    rx_bytes_q[$];
  result_t     owed_results_q[$];
  int unsigned total_bytes;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;

  // Local copy of the parser state.
  phase_e               dec_phase;
  logic [SizeWidth-1:0] size_acc;
  logic [SizeWidth-1:0] chunk_left;
  logic [LenWidth-1:0]  payload_total;
  err_e                 dec_err;
  logic                 dec_done;

  // Stretches of cycles in which one side never idles.
  logic        src_calm;
  logic        snk_calm;
  int unsigned cycle_cnt;
  int unsigned send_gap;
  int unsigned take_gap;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    dec_phase     = PhSize;
    size_acc      = '0;
    chunk_left    = '0;
    payload_total = '0;
    dec_err       = ErrNone;
    dec_done      = 1'b0;
  endfunction

  // Value of a hex digit in either case, or -1 for any other character.
  function automatic int hex_digit(logic [ByteWidth-1:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'(8'("0"));
    if (c >= "a" && c <= "f") return int'(c) - int'(8'("a")) + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'(8'("A")) + 10;
    return -1;
  endfunction

  // Advance the parser by one byte and return the result it produces.
  function automatic result_t decode_byte(logic [ByteWidth-1:0] c, logic body);
    result_t r;
    int      dig;
    logic    emit;
    emit = 1'b0;
    r    = '0;
    if (!body) begin
      // header byte: restart the body, nothing else happens
      clear_decoder();
    end else if (dec_err == ErrNone && !dec_done) begin
      case (dec_phase)
        PhSize: begin
          if (c == ChCr) begin
            dec_phase = PhSizeLf;
          end else begin
            dig = hex_digit(c);
            // reject a non-digit, and any digit that would push bits off the top
            if (dig < 0 || size_acc[SizeWidth-1 -: 4] != 4'd0) begin
              dec_err = ErrSizeLine;
            end else begin
              size_acc   = {size_acc[SizeWidth-5:0], 4'(dig)};
              chunk_left = 1;  // the line is no longer empty
            end
          end
        end
        PhSizeLf: begin
          if (c != ChLf || chunk_left == 0) begin
            dec_err = ErrSizeLine;
          end else if (size_acc == 0) begin
            chunk_left = '0;
            dec_phase  = PhTrailer;
          end else begin
            chunk_left = size_acc;
            size_acc   = '0;
            dec_phase  = PhData;
          end
        end
        PhData: begin
          if (chunk_left != 0) begin
            chunk_left    = chunk_left - 1'b1;
            payload_total = payload_total + 1'b1;
            emit          = 1'b1;
          end else if (c == ChCr) begin
            dec_phase = PhDataLf;
          end else begin
            dec_err = ErrFraming;
          end
        end
        PhDataLf: begin
          if (c != ChLf) begin
            dec_err = ErrFraming;
          end else begin
            size_acc   = '0;
            chunk_left = '0;
            dec_phase  = PhSize;
          end
        end
        PhTrailer: begin
          if (c == ChCr) dec_phase = PhTrailerLf;
          else chunk_left = 1;
        end
        PhTrailerLf: begin
          if (c == ChLf) begin
            // an empty trailer line ends the body
            if (chunk_left == 0) dec_done = 1'b1;
            chunk_left = '0;
            dec_phase  = PhTrailer;
          end else begin
            chunk_left = 1;
            if (c != ChCr) dec_phase = PhTrailer;
          end
        end
        default: begin
          dec_phase = PhSize;
        end
      endcase
    end
    r.data_byte      = emit ? c : '0;
    r.data_valid     = emit;
    r.done_res       = dec_done;
    r.error_code     = dec_err;
    r.decoded_length = payload_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic void push_byte(logic [ByteWidth-1:0] c, logic body);
    rx_byte_t b;
    b.c         = c;
    b.body      = body;
    b.hold_back = 1'b0;
    rx_bytes_q.push_back(b);
  endfunction

  function automatic void push_crlf();
    push_byte(ChCr, 1'b1);
    push_byte(ChLf, 1'b1);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b1);
  endfunction

  function automatic logic [ByteWidth-1:0] rand_byte();
    return ByteWidth'($urandom);
  endfunction

  // Hex digit character in a random case.
  function automatic logic [ByteWidth-1:0] hex_char(int d);
    logic [ByteWidth-1:0] base;
    if (d < 10) return 8'("0") + 8'(d);
    base = $urandom_range(0, 1) ? 8'("A") : 8'("a");
    return base + 8'(d - 10);
  endfunction

  // Size line for v, now and then with a leading zero, ended by CR LF.
  function automatic void push_size_line(logic [SizeWidth-1:0] v);
    int digits[$];
    while (v != 0) begin
      digits.push_front(int'(v[3:0]));
      v = v >> 4;
    end
    if (digits.size() == 0 || $urandom_range(0, 9) == 0) digits.push_front(0);
    foreach (digits[i]) push_byte(hex_char(digits[i]), 1'b1);
    push_crlf();
  endfunction

  function automatic logic [SizeWidth-1:0] pick_chunk_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return SizeWidth'($urandom_range(1, 16));
    if (r < 95) return SizeWidth'($urandom_range(17, 64));
    return SizeWidth'($urandom_range(65, 300));
  endfunction

  // Header bytes, a few chunks, the last chunk, trailer lines and stray bytes after done.
  function automatic void add_body();
    int unsigned          n;
    logic [SizeWidth-1:0] sz;
    logic [ByteWidth-1:0] c;
    n = $urandom_range(1, 2);
    repeat (n) push_byte(rand_byte(), 1'b0);
    n = $urandom_range(0, 3);
    repeat (n) begin
      sz = pick_chunk_size();
      push_size_line(sz);
      for (int unsigned i = 0; i < sz; i++) push_byte(rand_byte(), 1'b1);
      push_crlf();
    end
    push_size_line('0);
    n = $urandom_range(0, 2);
    repeat (n) begin
      repeat ($urandom_range(1, 6)) begin
        c = rand_byte();
        if (c == ChCr) c = "t";
        push_byte(c, 1'b1);
      end
      // a lone CR inside a trailer line is just another character
      if ($urandom_range(0, 5) == 0) push_byte(ChCr, 1'b1);
      push_crlf();
    end
    push_crlf();
    repeat ($urandom_range(0, 3)) push_byte(rand_byte(), 1'b1);
  endfunction

  function automatic void add_directed();
    // header bytes at both extremes
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // one payload byte, zero chunk, one trailer line, empty line, then a byte after done
    push_text("1");
    push_crlf();
    push_byte(8'hFF, 1'b1);
    push_crlf();
    push_text("0");
    push_crlf();
    push_text("x");
    push_crlf();
    push_crlf();
    push_text("Z");
    // empty size line
    push_byte(8'h55, 1'b0);
    push_crlf();
    // non-hex character in the size line, then a byte ignored after the error
    push_byte(8'hAA, 1'b0);
    push_text("aGb");
    // payload not followed by CR LF
    push_byte(8'h00, 1'b0);
    push_text("2");
    push_crlf();
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_text("X");
  endfunction

  function automatic void add_random_case();
    int unsigned          r;
    int unsigned          mark;
    int unsigned          idx;
    logic [SizeWidth-1:0] sz;
    logic [ByteWidth-1:0] bad_chars[7];
    bad_chars = '{";", " ", "-", "+", "g", "G", ChLf};
    mark = rx_bytes_q.size();
    r    = $urandom_range(0, 99);
    if (r < 55) begin
      add_body();
    end else if (r < 72) begin
      // framed body with one byte changed, or cut short
      add_body();
      idx = $urandom_range(mark + 1, rx_bytes_q.size() - 1);
      if ($urandom_range(0, 2) != 0) begin
        rx_bytes_q[idx].c = rand_byte();
      end else begin
        while (rx_bytes_q.size() > idx) void'(rx_bytes_q.pop_back());
      end
    end else if (r < 80) begin
      // one digit more than the accumulator holds, led by a non-zero digit
      push_byte(rand_byte(), 1'b0);
      push_byte(hex_char($urandom_range(1, 15)), 1'b1);
      repeat (SizeWidth / 4) push_byte(hex_char($urandom_range(0, 15)), 1'b1);
      push_crlf();
      repeat ($urandom_range(0, 4)) push_byte(rand_byte(), 1'b1);
    end else if (r < 86) begin
      // huge chunk: only its start is sent before the next header byte
      push_byte(rand_byte(), 1'b0);
      sz = $urandom_range(0, 1) ? '1 : SizeWidth'({$urandom, $urandom});
      if (sz == 0) sz = 1;
      push_size_line(sz);
      repeat ($urandom_range(3, 30)) push_byte(rand_byte(), 1'b1);
    end else if (r < 93) begin
      // size line with a bad character (extension, sign, space, bare LF), CR without LF, or empty
      push_byte(rand_byte(), 1'b0);
      repeat ($urandom_range(0, 2)) push_byte(hex_char($urandom_range(0, 15)), 1'b1);
      case ($urandom_range(0, 2))
        0: push_byte(bad_chars[$urandom_range(0, 6)], 1'b1);
        1: begin
          push_byte(ChCr, 1'b1);
          push_byte(rand_byte(), 1'b1);
        end
        default: push_crlf();
      endcase
      repeat ($urandom_range(0, 5)) push_byte(rand_byte(), 1'b1);
    end else begin
      // raw noise, mostly body bytes
      repeat ($urandom_range(5, 20)) push_byte(rand_byte(), $urandom_range(0, 7) != 0);
    end
    if (rx_bytes_q.size() > mark && $urandom_range(0, 19) == 0) begin
      rx_bytes_q[mark].hold_back = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idling
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap(logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Re-roll the calm stretches whenever the low byte of the cycle counter wraps to zero.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_cnt <= 0;
      src_calm  <= 1'b0;
      snk_calm  <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt[7:0] == 8'd0) begin
        src_calm <= ($urandom_range(0, 3) == 0);
        snk_calm <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the queued bytes, predict each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    rx_byte_t b;
    logic     holding;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.byte_in <= '0;
      in_if.in_body <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        owed_results_q.push_back(decode_byte(in_if.byte_in, in_if.in_body));
        bytes_taken++;
        holding = 1'b0;
      end else begin
        holding = in_if.valid;
      end
      if (holding) begin
        // hold the offered byte until it is taken
      end else if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (rx_bytes_q.size() != 0 &&
                   !(rx_bytes_q[0].hold_back && owed_results_q.size() != 0)) begin
        b = rx_bytes_q.pop_front();
        in_if.valid   <= 1'b1;
        in_if.byte_in <= b.c;
        in_if.in_body <= b.body;
        send_gap      <= pick_gap(src_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, compare each taken result with the oldest owed one
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_gap     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (owed_results_q.size() == 0) begin
          flag_mismatch("unexpected result", out_if.decoded_length, '0);
        end else begin
          want = owed_results_q.pop_front();
          if (out_if.data_byte !== want.data_byte)
            flag_mismatch("data_byte", out_if.data_byte, want.data_byte);
          if (out_if.data_valid !== want.data_valid)
            flag_mismatch("data_valid", out_if.data_valid, want.data_valid);
          if (out_if.done_res !== want.done_res)
            flag_mismatch("done_res", out_if.done_res, want.done_res);
          if (out_if.error_code !== want.error_code)
            flag_mismatch("error_code", out_if.error_code, want.error_code);
          if (out_if.decoded_length !== want.decoded_length)
            flag_mismatch("decoded_length", out_if.decoded_length, want.decoded_length);
        end
      end
      if (take_gap != 0) begin
        take_gap     <= take_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        take_gap     <= pick_gap(snk_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    clear_decoder();

    add_directed();
    // the first random case waits for the directed results to drain
    rx_bytes_q[rx_bytes_q.size() - 1].hold_back = 1'b0;
    begin
      int unsigned first_random;
      first_random = rx_bytes_q.size();
      while (rx_bytes_q.size() < first_random + 800) add_random_case();
      rx_bytes_q[first_random].hold_back = 1'b1;
    end
    total_bytes = rx_bytes_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != total_bytes || owed_results_q.size() != 0) @(posedge clk_i);
    // allow a stray extra result to show up
    repeat (6) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("timeout: %0d of %0d bytes taken, %0d results owed",
             bytes_taken, total_bytes, owed_results_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
